### hw/rtl/bcht_pkg.sv
// shared types and constants of the byte change highlight tracker
// depends on nothing; every other file of the block but bcht_ram imports it
package bcht_pkg;

  localparam int unsigned ENTRIES = 256;
  localparam int unsigned IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned PADDR_W = 4;

  localparam logic [7:0]  FADE_RESET = 8'h30;
  localparam logic [15:0] REST_RESET = 16'h60;

  // register indexes on the apb port (byte address 4*i)
  localparam logic [1:0] REG_FADE_FRAMES = 2'd0;
  localparam logic [1:0] REG_REST_FRAMES = 2'd1;
  localparam logic [1:0] REG_KEEP_MARKS  = 2'd2;

  localparam logic ITEM_SAMPLE = 1'b0;
  localparam logic ITEM_LOAD   = 1'b1;

  localparam logic [3:0] SHADE_UNTOUCHED_NZ = 4'd0;
  localparam logic [3:0] SHADE_UNTOUCHED_Z  = 4'd1;
  localparam logic [3:0] SHADE_MARK_BASE    = 4'd2;

  typedef enum logic [1:0] {
    KIND_INC1 = 2'd0,
    KIND_INCN = 2'd1,
    KIND_DEC1 = 2'd2,
    KIND_DECN = 2'd3
  } kind_e;

  typedef enum logic {
    ST_IDLE,
    ST_UPDATE
  } state_e;

  typedef struct packed {
    logic [7:0]  fade_frames;
    logic [15:0] rest_frames;
    logic        keep_marks;
  } cfg_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] entry_index;
    logic [7:0] new_value;
  } in_t;

  typedef struct packed {
    logic [7:0] entry_out;
    logic [7:0] value_out;
    logic [3:0] shade;
  } out_t;

  typedef struct packed {
    logic [7:0]  stored_byte;
    logic        untouched;
    kind_e       change_kind;
    logic [7:0]  fade_count;
    logic [15:0] rest_count;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  function automatic logic [3:0] shade_of(entry_t e);
    logic [3:0] s;
    if (e.untouched) begin
      s = (e.stored_byte != 8'd0) ? SHADE_UNTOUCHED_NZ : SHADE_UNTOUCHED_Z;
    end else begin
      s = SHADE_MARK_BASE + {1'b0, e.change_kind, (e.fade_count == 8'd0)};
    end
    return s;
  endfunction

endpackage

### hw/rtl/bcht_ram.sv
// generic single-write, single-read ram with registered read data
// standalone, no package needed
module bcht_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                         wdata_i,
  input  logic                                     re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/bcht_regs.sv
// apb configuration registers: fade length, rest length, keep marks
// depends on bcht_pkg
module bcht_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bcht_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  output bcht_pkg::cfg_t                cfg_o
);
  import bcht_pkg::*;

  cfg_t       cfg_q, cfg_d;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = paddr[3:2];

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_idx)
        REG_FADE_FRAMES: cfg_d.fade_frames = pwdata[7:0];
        REG_REST_FRAMES: cfg_d.rest_frames = pwdata[15:0];
        REG_KEEP_MARKS:  cfg_d.keep_marks  = pwdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.fade_frames <= FADE_RESET;
      cfg_q.rest_frames <= REST_RESET;
      cfg_q.keep_marks  <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  always_comb begin
    case (reg_idx)
      REG_FADE_FRAMES: prdata = {24'd0, cfg_q.fade_frames};
      REG_REST_FRAMES: prdata = {16'd0, cfg_q.rest_frames};
      REG_KEEP_MARKS:  prdata = {31'd0, cfg_q.keep_marks};
      default:         prdata = 32'd0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

### hw/rtl/bcht_update.sv
// per-entry modify step: decay, compare, reload, and the display shade
// depends on bcht_pkg
module bcht_update (
  input  bcht_pkg::cfg_t   cfg_i,
  input  bcht_pkg::in_t    item_i,
  input  logic             in_range_i,
  input  bcht_pkg::entry_t entry_i,
  output logic             wr_en_o,
  output bcht_pkg::entry_t entry_o,
  output bcht_pkg::out_t   result_o
);
  import bcht_pkg::*;

  entry_t     nxt;
  logic [7:0] old_b;
  logic [7:0] nv;
  logic [7:0] diff_up;
  logic [7:0] diff_dn;

  assign old_b   = entry_i.stored_byte;
  assign nv      = item_i.new_value;
  assign diff_up = nv - old_b;
  assign diff_dn = old_b - nv;

  always_comb begin
    nxt = entry_i;
    if (item_i.kind == ITEM_LOAD) begin
      nxt.untouched   = 1'b1;
      nxt.change_kind = KIND_DEC1;
      nxt.fade_count  = cfg_i.fade_frames;
      nxt.rest_count  = cfg_i.rest_frames;
    end else begin
      // decays first
      if (!entry_i.untouched && entry_i.fade_count != 8'd0) begin
        nxt.fade_count = entry_i.fade_count - 8'd1;
      end
      if (entry_i.rest_count == 16'd0) begin
        nxt.untouched = 1'b1;
      end
      if (!nxt.untouched && entry_i.rest_count != 16'd0 && !cfg_i.keep_marks) begin
        nxt.rest_count = entry_i.rest_count - 16'd1;
      end
      if (nv != old_b) begin
        nxt.untouched = 1'b0;
        if (nv > old_b) begin
          nxt.change_kind = (diff_up == 8'd1) ? KIND_INC1 : KIND_INCN;
        end else begin
          nxt.change_kind = (diff_dn == 8'd1) ? KIND_DEC1 : KIND_DECN;
        end
        nxt.fade_count = cfg_i.fade_frames;
        nxt.rest_count = cfg_i.rest_frames;
      end
    end
    nxt.stored_byte = nv;
  end

  assign wr_en_o = in_range_i;
  assign entry_o = nxt;

  always_comb begin
    result_o.entry_out = item_i.entry_index;
    result_o.value_out = nv;
    if (in_range_i) begin
      result_o.shade = shade_of(nxt);
    end else begin
      result_o.shade = (nv != 8'd0) ? SHADE_UNTOUCHED_NZ : SHADE_UNTOUCHED_Z;
    end
  end

endmodule

### hw/rtl/byte_change_highlight_tracker.sv
// top level of the byte change highlight tracker: entry memory, control, output register
// depends on bcht_pkg, bcht_ram, bcht_regs and bcht_update
//
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_data_i) takes one transaction per
//   item: kind (sample or load), entry_index and new_value. Output channel
//   (out_valid_o / out_stall_i / out_data_o) returns one transaction per item:
//   entry_out, value_out and shade, in acceptance order.
//   The entry is read from the state memory in the cycle of acceptance, then
//   modified in the update state, written back and placed in the output
//   register. The interlock holds the next item until the current entry is
//   written back, so a new item is not taken before the last one is through.
//   While the output register is full and stalled, no new item is accepted; an
//   item can be accepted in the same cycle the previous result is taken.
//   Reset clears control, loads fade length 48, rest length 96, keep_marks 0 and
//   marks every entry as at its initial state through per-entry valid bits, so
//   no clearing pass is needed and items are taken right after reset.
//   Configuration goes through the apb port; the user must write it only while
//   no item is in flight, as the block does not enforce this.
module byte_change_highlight_tracker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  bcht_pkg::in_t                 in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output bcht_pkg::out_t                out_data_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bcht_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import bcht_pkg::*;

  state_e             state_q, state_d;
  in_t                item_q;
  out_t               out_q;
  logic               out_valid_q, out_valid_d;
  logic [ENTRIES-1:0] valid_q;
  cfg_t               cfg;
  logic               in_accept;
  logic [15:0]        in_idx_wide;
  logic [15:0]        item_idx_wide;
  logic [IDX_W-1:0]   rd_addr;
  logic [IDX_W-1:0]   item_addr;
  logic               item_in_range;
  logic [ENTRY_W-1:0] ram_rdata;
  entry_t             entry_rd;
  entry_t             entry_wr;
  logic               upd_wr;
  logic               ram_we;
  out_t               result;

  bcht_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign in_stall_o = (state_q != ST_IDLE) || (out_valid_q && out_stall_i);
  assign in_accept  = in_valid_i && !in_stall_o;

  assign in_idx_wide   = 16'(in_data_i.entry_index);
  assign item_idx_wide = 16'(item_q.entry_index);
  assign rd_addr       = in_idx_wide[IDX_W-1:0];
  assign item_addr     = item_idx_wide[IDX_W-1:0];
  assign item_in_range = 32'(item_q.entry_index) < ENTRIES;

  bcht_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (item_addr),
    .wdata_i (entry_wr),
    .re_i    (in_accept),
    .raddr_i (rd_addr),
    .rdata_o (ram_rdata)
  );

  // never-written entries read as their initial state; the byte is left as read
  always_comb begin
    entry_rd = entry_t'(ram_rdata);
    if (!valid_q[item_addr]) begin
      entry_rd.untouched   = 1'b1;
      entry_rd.change_kind = KIND_DEC1;
      entry_rd.fade_count  = FADE_RESET;
      entry_rd.rest_count  = REST_RESET;
    end
  end

  bcht_update u_update (
    .cfg_i      (cfg),
    .item_i     (item_q),
    .in_range_i (item_in_range),
    .entry_i    (entry_rd),
    .wr_en_o    (upd_wr),
    .entry_o    (entry_wr),
    .result_o   (result)
  );

  assign ram_we = (state_q == ST_UPDATE) && upd_wr;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && out_stall_i;
    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          state_d = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        state_d     = ST_IDLE;
        out_valid_d = 1'b1;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      valid_q     <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (ram_we) begin
        valid_q[item_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      item_q <= in_data_i;
    end
    if (state_q == ST_UPDATE) begin
      out_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  // a new result only appears right after an update cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_UPDATE))
    else $error("result without update cycle");

  // the entry memory is written only in the update cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == ST_UPDATE))
    else $error("memory write outside update cycle");

  // an accepted transaction always moves to the update cycle with a free output register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> (state_q == ST_UPDATE) && !out_valid_q)
    else $error("accepted transaction not updated");
`endif

endmodule

### bench/tb_byte_change_highlight_tracker.sv
// testbench for byte_change_highlight_tracker: directed change and decay cases, then random traffic
// keeps its own per-entry tracker state; needs bcht_pkg and the block's rtl
module tb_byte_change_highlight_tracker;
  import bcht_pkg::*;

  localparam int unsigned STALL_LIMIT = 2000;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_stall_o;
  in_t                  in_data_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  out_t                 out_data_o;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [PADDR_W-1:0]   paddr;
  logic [31:0]          pwdata;
  logic [31:0]          prdata;
  logic                 pready;

  byte_change_highlight_tracker u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  // tracker state as the block should hold it
  logic [7:0]  tb_byte      [256];
  bit          tb_untouched [256];
  kind_e       tb_kind      [256];
  logic [7:0]  tb_fade      [256];
  logic [15:0] tb_rest      [256];
  bit          tb_written   [256];
  logic [7:0]  cfg_fade;
  logic [15:0] cfg_rest;
  logic        cfg_keep;

  out_t        expected_views[$];
  int          errors;
  int          items_sent;
  int          views_seen;
  int          settings_used;
  int unsigned quiet_cycles;
  bit          steady;

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // applies one accepted transaction to the tracker state and returns the view it should give
  function automatic out_t track_entry(input in_t it);
    out_t       res;
    logic [7:0] e;
    logic [7:0] nv;
    logic [7:0] old;
    e  = it.entry_index;
    nv = it.new_value;
    res.entry_out = e;
    res.value_out = nv;
    if (int'(e) >= int'(ENTRIES)) begin
      res.shade = (nv != 8'd0) ? SHADE_UNTOUCHED_NZ : SHADE_UNTOUCHED_Z;
      return res;
    end
    tb_written[e] = 1'b1;
    if (it.kind == ITEM_LOAD) begin
      tb_byte[e]      = nv;
      tb_untouched[e] = 1'b1;
      tb_kind[e]      = KIND_DEC1;
      tb_fade[e]      = cfg_fade;
      tb_rest[e]      = cfg_rest;
    end else begin
      old = tb_byte[e];
      if (!tb_untouched[e] && tb_fade[e] != 8'd0) tb_fade[e] = tb_fade[e] - 8'd1;
      if (tb_rest[e] == 16'd0) tb_untouched[e] = 1'b1;
      if (!tb_untouched[e] && tb_rest[e] != 16'd0 && !cfg_keep) tb_rest[e] = tb_rest[e] - 16'd1;
      if (nv != old) begin
        tb_untouched[e] = 1'b0;
        if (nv > old) tb_kind[e] = (nv - old == 8'd1) ? KIND_INC1 : KIND_INCN;
        else tb_kind[e] = (old - nv == 8'd1) ? KIND_DEC1 : KIND_DECN;
        tb_fade[e] = cfg_fade;
        tb_rest[e] = cfg_rest;
      end
      tb_byte[e] = nv;
    end
    if (tb_untouched[e]) begin
      res.shade = (tb_byte[e] != 8'd0) ? SHADE_UNTOUCHED_NZ : SHADE_UNTOUCHED_Z;
    end else begin
      res.shade = SHADE_MARK_BASE + 4'(2 * int'(tb_kind[e])) + ((tb_fade[e] == 8'd0) ? 4'd1 : 4'd0);
    end
    return res;
  endfunction

  // mostly the stored byte or its neighbors on a small set of entries so that decays show up
  function automatic in_t random_item(input bit narrow);
    in_t        it;
    logic [7:0] e;
    int         pick;
    e = narrow ? {($urandom_range(1) != 0) ? 5'h1f : 5'h00, 3'($urandom_range(7))}
               : 8'($urandom);
    pick = $urandom_range(9);
    it.entry_index = e;
    if (pick < 3) it.new_value = tb_byte[e];
    else if (pick < 5) it.new_value = tb_byte[e] + 8'd1;
    else if (pick < 7) it.new_value = tb_byte[e] - 8'd1;
    else it.new_value = 8'($urandom);
    // an entry must be loaded before it is ever sampled
    it.kind = (!tb_written[e] || $urandom_range(9) == 0) ? ITEM_LOAD : ITEM_SAMPLE;
    return it;
  endfunction

  task automatic send_item(input in_t item);
    while (!steady && $urandom_range(99) < 24) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do @(posedge clk_i); while (in_stall_o);
    expected_views.push_back(track_entry(item));
    items_sent++;
  endtask

  task automatic send_fields(input logic kind, input logic [7:0] e, input logic [7:0] v);
    in_t it;
    it.kind        = kind;
    it.entry_index = e;
    it.new_value   = v;
    send_item(it);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (expected_views.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic apb_write(input logic [1:0] idx, input logic [31:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_FADE_FRAMES: cfg_fade = val[7:0];
      REG_REST_FRAMES: cfg_rest = val[15:0];
      REG_KEEP_MARKS:  cfg_keep = val[0];
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [7:0] fade, input logic [15:0] rest, input logic keep);
    wait_drained();
    apb_write(REG_FADE_FRAMES, {24'd0, fade});
    apb_write(REG_REST_FRAMES, {16'd0, rest});
    apb_write(REG_KEEP_MARKS, {31'd0, keep});
    settings_used++;
  endtask

  task automatic run_random_phase(input int count, input bit pause_midway);
    for (int n = 0; n < count; n++) begin
      if (pause_midway && n == count / 2) wait_drained();
      send_item(random_item($urandom_range(9) < 8));
    end
  endtask

  // every change kind at reset settings, extreme bytes and entries
  task automatic test_change_kinds();
    send_fields(ITEM_LOAD,   8'd0,   8'h00);
    send_fields(ITEM_LOAD,   8'd255, 8'hff);
    send_fields(ITEM_LOAD,   8'd128, 8'h7f);
    send_fields(ITEM_SAMPLE, 8'd0,   8'h01);
    send_fields(ITEM_SAMPLE, 8'd0,   8'h05);
    send_fields(ITEM_SAMPLE, 8'd0,   8'h04);
    send_fields(ITEM_SAMPLE, 8'd0,   8'h00);
    send_fields(ITEM_SAMPLE, 8'd0,   8'h00);
    send_fields(ITEM_SAMPLE, 8'd255, 8'h00);
    send_fields(ITEM_SAMPLE, 8'd255, 8'hff);
    send_fields(ITEM_SAMPLE, 8'd128, 8'h80);
    send_fields(ITEM_SAMPLE, 8'd128, 8'h7f);
    send_fields(ITEM_LOAD,   8'd0,   8'haa);
  endtask

  // fade and rest counters running out, and frozen marks
  task automatic test_decay_edges();
    set_config(8'd0, 16'd0, 1'b0);
    send_fields(ITEM_LOAD,   8'd1, 8'd10);
    send_fields(ITEM_SAMPLE, 8'd1, 8'd11);
    send_fields(ITEM_SAMPLE, 8'd1, 8'd11);
    set_config(8'd1, 16'd2, 1'b0);
    send_fields(ITEM_LOAD,   8'd2, 8'd3);
    repeat (4) send_fields(ITEM_SAMPLE, 8'd2, 8'd4);
    set_config(8'hff, 16'hffff, 1'b1);
    send_fields(ITEM_LOAD,   8'd3, 8'd0);
    send_fields(ITEM_SAMPLE, 8'd3, 8'd200);
    send_fields(ITEM_SAMPLE, 8'd3, 8'd200);
    send_fields(ITEM_SAMPLE, 8'd3, 8'd199);
  endtask

  task automatic test_random_fixed_settings();
    set_config(FADE_RESET, REST_RESET, 1'b0);
    run_random_phase(85, 1'b0);
    set_config(8'd0, 16'd0, 1'b0);
    run_random_phase(85, 1'b0);
    set_config(8'hff, 16'hffff, 1'b1);
    run_random_phase(85, 1'b0);
  endtask

  task automatic test_random_swept_settings();
    // no idling on either side in the first run, and one full drain halfway through it
    set_config(8'($urandom_range(3)), 16'($urandom_range(5)), 1'b0);
    steady = 1'b1;
    run_random_phase(85, 1'b1);
    steady = 1'b0;
    set_config(8'($urandom), 16'($urandom_range(15)), 1'($urandom_range(1)));
    run_random_phase(85, 1'b0);
    set_config(8'($urandom), 16'($urandom), 1'($urandom_range(1)));
    run_random_phase(85, 1'b0);
  endtask

  always @(posedge clk_i) begin
    out_stall_i <= (!steady && $urandom_range(99) < 24);
  end

  always @(posedge clk_i) begin
    out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      views_seen++;
      if (expected_views.size() == 0) begin
        errors++;
        $display("%0t unexpected transaction: expected none, actual %h", $time, out_data_o);
      end else begin
        want = expected_views.pop_front();
        if (out_data_o.entry_out !== want.entry_out) begin
          errors++;
          $display("%0t entry_out: expected %0d, actual %0d", $time, want.entry_out,
                   out_data_o.entry_out);
        end
        if (out_data_o.value_out !== want.value_out) begin
          errors++;
          $display("%0t value_out: expected %h, actual %h", $time, want.value_out,
                   out_data_o.value_out);
        end
        if (out_data_o.shade !== want.shade) begin
          errors++;
          $display("%0t shade: expected %0d, actual %0d", $time, want.shade, out_data_o.shade);
        end
      end
    end
  end

  // stop a hung run: count cycles with no transaction on either channel
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    for (int i = 0; i < 256; i++) begin
      tb_byte[i]      = 8'd0;
      tb_untouched[i] = 1'b1;
      tb_kind[i]      = KIND_DEC1;
      tb_fade[i]      = FADE_RESET;
      tb_rest[i]      = REST_RESET;
      tb_written[i]   = 1'b0;
    end
    cfg_fade      = FADE_RESET;
    cfg_rest      = REST_RESET;
    cfg_keep      = 1'b0;
    errors        = 0;
    items_sent    = 0;
    views_seen    = 0;
    settings_used = 0;
    steady        = 1'b0;
    quiet_cycles  <= 0;
    rst_ni        <= 1'b0;
    in_valid_i    <= 1'b0;
    in_data_i     <= '0;
    out_stall_i   <= 1'b0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_change_kinds();
    test_decay_edges();
    test_random_fixed_settings();
    test_random_swept_settings();

    wait_drained();
    repeat (4) @(posedge clk_i);
    $display("covered %0d input transactions and %0d results over %0d register settings,",
             items_sent, views_seen, settings_used);
    $display("including zero and full-scale fade/rest and frozen marks");
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
